@@ hw/rtl/mipds_pkg.sv @@
// Shared types, constants and reduction helpers for the mip level downsampler.
`timescale 1ns / 1ps

package mipds_pkg;

  // Default largest source width, in pixels.
  localparam int MAX_WIDTH_DEF = 4096;

  // Width of one color channel and of the size registers.
  localparam int CHAN_W = 16;
  localparam int SIZE_W = 13;
  localparam int NUM_CHAN = 4;

  // A horizontal pair result needs one carry bit; a full 2x2 sum needs two.
  localparam int PAIR_W = CHAN_W + 1;
  localparam int ACC_W = CHAN_W + 2;

  // Configuration port.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = SIZE_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_WIDTH   = 2'd0,
    CFG_SOURCE_HEIGHT  = 2'd1,
    CFG_REDUCE_MODE    = 2'd2,
    CFG_SINGLE_CHANNEL = 2'd3
  } cfg_idx_t;

  // Reduction operator over a 2x2 block.
  typedef enum logic [1:0] {
    MODE_AVG = 2'd0,
    MODE_MIN = 2'd1,
    MODE_MAX = 2'd2
  } mode_t;

  // The unused mode code falls back to average.
  function automatic mode_t decode_mode(logic [1:0] code);
    mode_t m;
    case (code)
      MODE_MIN: m = MODE_MIN;
      MODE_MAX: m = MODE_MAX;
      default:  m = MODE_AVG;
    endcase
    return m;
  endfunction

  // Combines two partial results: sum for average, else minimum or maximum.
  function automatic logic [ACC_W-1:0] reduce_two(mode_t m, logic [PAIR_W-1:0] p,
                                                  logic [PAIR_W-1:0] q);
    logic [ACC_W-1:0] r;
    case (m)
      MODE_MIN: r = (p < q) ? {1'b0, p} : {1'b0, q};
      MODE_MAX: r = (p > q) ? {1'b0, p} : {1'b0, q};
      default:  r = {1'b0, p} + {1'b0, q};
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/mip_level_downsampler.sv @@
// A result enters stage 1 with its bottom-right pixel, then the output register.
// Throughput: one source pixel per cycle while in_stall is low, set by the single read
// and write ports of the line store: one read per pixel pair, one write per top-row pair.
// Reset (synchronous, active low) clears the counters, the pipeline valids and the held
// left pixel and restores the 2x2 average, four-channel configuration; the line store is
// not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module mip_level_downsampler import mipds_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration writes.
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Source pixel channel.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CHAN_W-1:0]     in_chan0_in,
  input  logic [CHAN_W-1:0]     in_chan1_in,
  input  logic [CHAN_W-1:0]     in_chan2_in,
  input  logic [CHAN_W-1:0]     in_chan3_in,
  // Reduced pixel channel.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHAN_W-1:0]     out_chan0_out,
  output logic [CHAN_W-1:0]     out_chan1_out,
  output logic [CHAN_W-1:0]     out_chan2_out,
  output logic [CHAN_W-1:0]     out_chan3_out,
  output logic                  out_level_done
);

  localparam int CNT_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int DIM_W = ($clog2(MAX_WIDTH + 1) > SIZE_W) ? $clog2(MAX_WIDTH + 1) : SIZE_W;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int SLOT_W = (CNT_W > 1) ? CNT_W - 1 : 1;
  localparam int MEM_W = 2 * PAIR_W;
  localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] ONE_DIM = DIM_W'(1);

  // Configuration registers.
  logic [SIZE_W-1:0] src_w_r;
  logic [SIZE_W-1:0] src_h_r;
  logic [1:0]        mode_code_r;
  logic              single_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r     <= SIZE_W'(2);
      src_h_r     <= SIZE_W'(2);
      mode_code_r <= MODE_AVG;
      single_r    <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SOURCE_WIDTH:   src_w_r     <= cfg_data;
        CFG_SOURCE_HEIGHT:  src_h_r     <= cfg_data;
        CFG_REDUCE_MODE:    mode_code_r <= cfg_data[1:0];
        CFG_SINGLE_CHANNEL: single_r    <= cfg_data[0];
        default:            single_r    <= single_r;
      endcase
    end
  end

  mode_t mode;
  assign mode = decode_mode(mode_code_r);

  // Effective sizes: zero acts as one, and sizes are clamped to the line store.
  logic [DIM_W-1:0] w_raw, h_raw, w_eff, h_eff, used_w, used_h;

  assign w_raw  = DIM_W'(src_w_r);
  assign h_raw  = DIM_W'(src_h_r);
  assign w_eff  = (w_raw == '0) ? ONE_DIM : ((w_raw > MAX_DIM) ? MAX_DIM : w_raw);
  assign h_eff  = (h_raw == '0) ? ONE_DIM : ((h_raw > MAX_DIM) ? MAX_DIM : h_raw);
  assign used_w = {w_eff[DIM_W-1:1], 1'b0};
  assign used_h = {h_eff[DIM_W-1:1], 1'b0};

  // Pipeline control and handshakes.
  logic s1_valid_r, s1_emit_r, s1_adv, in_accept, out_valid_r;

  assign s1_adv    = !s1_valid_r || !s1_emit_r || !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  // Position of the next source pixel.
  logic [CNT_W-1:0] col_r, row_r, col_nxt, row_nxt;
  logic [DIM_W-1:0] x_ext, y_ext, x_inc, y_inc;
  logic             in_blk, col_odd, pair_go, last_blk;
  logic [SLOT_W-1:0] slot;

  assign x_ext    = DIM_W'(col_r);
  assign y_ext    = DIM_W'(row_r);
  assign x_inc    = x_ext + ONE_DIM;
  assign y_inc    = y_ext + ONE_DIM;
  assign in_blk   = (x_ext < used_w) && (y_ext < used_h);
  assign col_odd  = col_r[0];
  assign pair_go  = in_accept && in_blk && col_odd;
  assign last_blk = (x_ext == used_w - ONE_DIM) && (y_ext == used_h - ONE_DIM);
  assign slot     = SLOT_W'(col_r >> 1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_accept) begin
      if (x_inc >= w_eff) begin
        col_nxt = '0;
        row_nxt = (y_inc >= h_eff) ? '0 : CNT_W'(y_inc);
      end else begin
        col_nxt = CNT_W'(x_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Even-column pixel held for the horizontal pair.
  logic [CHAN_W-1:0] pix [NUM_CHAN];
  logic [CHAN_W-1:0] hold_r [NUM_CHAN];

  assign pix[0] = in_chan0_in;
  assign pix[1] = in_chan1_in;
  assign pix[2] = in_chan2_in;
  assign pix[3] = in_chan3_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CHAN; c++) hold_r[c] <= '0;
    end else if (in_accept && in_blk && !col_odd) begin
      for (int c = 0; c < NUM_CHAN; c++) hold_r[c] <= pix[c];
    end
  end

  // Horizontal pair of the held pixel and the current one.
  logic [PAIR_W-1:0] pair [NUM_CHAN];

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      pair[c] = PAIR_W'(reduce_two(mode, {1'b0, hold_r[c]}, {1'b0, pix[c]}));
    end
  end

  // Stage 1: pair results wait here while the line store read completes.
  logic [PAIR_W-1:0] s1_pair_r [NUM_CHAN];
  logic [SLOT_W-1:0] s1_slot_r;
  logic              s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_emit_r  <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= pair_go;
      s1_emit_r  <= row_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (pair_go) begin
      for (int c = 0; c < NUM_CHAN; c++) s1_pair_r[c] <= pair[c];
      s1_slot_r <= slot;
      s1_last_r <= last_blk;
    end
  end

  // Line store: top-row pairs, channels 0/1 in the low memory, 2/3 in the high memory.
  // A top-row write lands before the bottom-row read of the same slot,
  // since a whole source row lies between them.
  logic [MEM_W-1:0] line_lo [LINE_DEPTH];
  logic [MEM_W-1:0] line_hi [LINE_DEPTH];
  logic [MEM_W-1:0] lo_q_r, hi_q_r;
  logic             mem_we;

  assign mem_we = s1_valid_r && !s1_emit_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_lo[s1_slot_r] <= {s1_pair_r[0], s1_pair_r[1]};
    end
    if (pair_go) begin
      lo_q_r <= line_lo[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_hi[s1_slot_r] <= {s1_pair_r[2], s1_pair_r[3]};
    end
    if (pair_go) begin
      hi_q_r <= line_hi[slot];
    end
  end

  // Vertical combine of the stored top pair with the bottom pair.
  logic [PAIR_W-1:0] top [NUM_CHAN];
  logic [ACC_W-1:0]  full [NUM_CHAN];
  logic [CHAN_W-1:0] res [NUM_CHAN];

  assign top[0] = lo_q_r[MEM_W-1:PAIR_W];
  assign top[1] = lo_q_r[PAIR_W-1:0];
  assign top[2] = hi_q_r[MEM_W-1:PAIR_W];
  assign top[3] = hi_q_r[PAIR_W-1:0];

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      full[c] = reduce_two(mode, top[c], s1_pair_r[c]);
      res[c]  = (mode == MODE_AVG) ? full[c][ACC_W-1:2] : full[c][CHAN_W-1:0];
      if (single_r && (c != 0)) res[c] = '0;
    end
  end

  // Output register: holds a finished transaction while the next pixels flow in.
  logic              out_load;
  logic [CHAN_W-1:0] out_chan_r [NUM_CHAN];
  logic              out_last_r;

  assign out_load = s1_valid_r && s1_emit_r && s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int c = 0; c < NUM_CHAN; c++) out_chan_r[c] <= res[c];
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_chan0_out  = out_chan_r[0];
  assign out_chan1_out  = out_chan_r[1];
  assign out_chan2_out  = out_chan_r[2];
  assign out_chan3_out  = out_chan_r[3];
  assign out_level_done = out_last_r;

endmodule
